[rtl/core/tlvp_pkg.sv]
`timescale 1ns / 1ps

package tlvp_pkg;

    // Field widths of the request and result items
    localparam int CMD_W      = 2;
    localparam int LEN_W      = 16;
    localparam int BYTE_W     = 8;
    localparam int EIDX_W     = 4;
    localparam int KIND_W     = 5;
    localparam int TYPE_W     = 14;
    localparam int STATUS_W   = 3;
    localparam int MAXTYPE_W  = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TYPE  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY_ON = 4'd1;

    // Policy kinds
    localparam logic [KIND_W-1:0] KIND_LIMIT  = 5'd15;
    localparam logic [KIND_W-1:0] KIND_STRING = 5'd5;

    // Header size in bytes
    localparam logic [LEN_W-1:0] HDR_BYTES = 16'd4;

    // Result queue
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = RES_PTR_W + 1;

    typedef enum logic [1:0] {
        CMD_BEGIN  = 2'd0,
        CMD_BYTE   = 2'd1,
        CMD_POLICY = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_PAD     = 2'd3
    } t_phase;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_KIND  = 3'd1,
        ST_TOO_SHORT = 3'd2,
        ST_TOO_LONG  = 3'd3,
        ST_UNTERM    = 3'd4
    } t_status;

    typedef enum logic {
        RES_REPORT  = 1'b0,
        RES_SUMMARY = 1'b1
    } t_res_kind;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [LEN_W-1:0]  stream_length;
        logic [BYTE_W-1:0] data_byte;
        logic [EIDX_W-1:0] entry_index;
        logic [KIND_W-1:0] entry_kind;
        logic [LEN_W-1:0]  entry_min_len;
        logic [LEN_W-1:0]  entry_max_len;
    } t_in_item;

    typedef struct packed {
        logic                kind;
        logic [TYPE_W-1:0]   attr_type;
        logic [LEN_W-1:0]    attr_offset;
        logic [LEN_W-1:0]    payload_length;
        logic                duplicate;
        logic                ignored;
        logic [STATUS_W-1:0] status;
        logic [LEN_W-1:0]    leftover;
        logic                last;
    } t_result;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [LEN_W-1:0]  min_len;
        logic [LEN_W-1:0]  max_len;
    } t_policy;

    // Default minimum payload per kind when the entry gives none
    function automatic logic [3:0] f_default_min(input logic [3:0] kind);
        logic [3:0] v;
        case (kind)
            4'd1:    v = 4'd1;
            4'd2:    v = 4'd2;
            4'd3:    v = 4'd4;
            4'd4:    v = 4'd8;
            4'd5:    v = 4'd1;
            default: v = 4'd0;
        endcase
        return v;
    endfunction

    function automatic t_result f_report(input logic [TYPE_W-1:0] attr_type,
                                         input logic [LEN_W-1:0]  offset,
                                         input logic [LEN_W-1:0]  plen,
                                         input logic              dup,
                                         input logic              ign,
                                         input logic              last);
        t_result r;
        r                = '0;
        r.kind           = RES_REPORT;
        r.attr_type      = attr_type;
        r.attr_offset    = offset;
        r.payload_length = plen;
        r.duplicate      = dup;
        r.ignored        = ign;
        r.last           = last;
        return r;
    endfunction

    function automatic t_result f_summary(input t_status          st,
                                          input logic [LEN_W-1:0] left,
                                          input logic             last);
        t_result r;
        r          = '0;
        r.kind     = RES_SUMMARY;
        r.status   = st;
        r.leftover = left;
        r.last     = last;
        return r;
    endfunction

endpackage

[rtl/core/tlvp_in_if.sv]
`timescale 1ns / 1ps

// Request channel: one command item per transfer
interface tlvp_in_if;
    logic                valid;
    logic                ready;
    tlvp_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/tlvp_out_if.sv]
`timescale 1ns / 1ps

// Result channel: one report or summary per transfer
interface tlvp_out_if;
    logic               valid;
    logic               ready;
    tlvp_pkg::t_result  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/tlvp_cfg_if.sv]
`timescale 1ns / 1ps

// Register write channel
interface tlvp_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [tlvp_pkg::CFG_IDX_W-1:0]      index;
    logic [tlvp_pkg::CFG_DATA_W-1:0]     wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

[rtl/core/tlvp_result_fifo.sv]
`timescale 1ns / 1ps

// Small result queue: takes up to two results a cycle, hands out one
module tlvp_result_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push0,
    input  logic              i_push1,
    input  tlvp_pkg::t_result i_data0,
    input  tlvp_pkg::t_result i_data1,
    output logic              o_space_ok,
    output logic              o_valid,
    output tlvp_pkg::t_result o_data,
    input  logic              i_ready
);
    import tlvp_pkg::*;

    t_result                r_mem [RES_DEPTH];
    logic [RES_PTR_W-1:0]   r_wr_ptr;
    logic [RES_PTR_W-1:0]   r_rd_ptr;
    logic [RES_CNT_W-1:0]   r_count;
    logic [RES_PTR_W-1:0]   wr_ptr1;
    logic                   pop;
    logic [RES_CNT_W-1:0]   push_cnt;

    assign wr_ptr1    = r_wr_ptr + RES_PTR_W'(1);
    assign pop        = o_valid && i_ready;
    assign push_cnt   = RES_CNT_W'(i_push0) + RES_CNT_W'(i_push1);
    assign o_valid    = (r_count != '0);
    assign o_data     = r_mem[r_rd_ptr];
    // room for the worst case of two results from the next request
    assign o_space_ok = (r_count <= RES_CNT_W'(RES_DEPTH - 2));

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + RES_PTR_W'(push_cnt);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + RES_PTR_W'(1);
            end
            r_count <= r_count + push_cnt - RES_CNT_W'(pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wr_ptr] <= i_data0;
        end
        if (i_push1) begin
            r_mem[wr_ptr1] <= i_data1;
        end
    end

endmodule

[rtl/core/tlv_attribute_policy_parser_top.sv]
`timescale 1ns / 1ps

// TLV attribute walker with per-type policy checks.
//
// i_in carries command requests: begin (stream length), stream byte, or a
// policy entry write. Every request is handled in the cycle it is accepted,
// so one request per cycle is taken while the result path keeps up.
// o_out carries results: one report per parsed attribute and one summary at
// the end of each walk; a request gives at most two, the last one flagged.
// Results are registered into the result queue and appear on o_out from its head.
// The rate is set by the four-entry result queue: i_in.ready drops while
// fewer than two entries are free, so a stalled receiver backs up into i_in
// once three results are waiting; no result is lost.
// i_cfg writes max_type (index 0) and policy_on (index 1); it is always
// ready and should be written only while the block is idle.
// Reset (synchronous, active low) leaves the walker idle, clears the seen
// set, zeroes the policy table (no checks), sets max_type to 15 and
// policy_on to 0, and empties the result queue.
module tlv_attribute_policy_parser_top #(
    parameter int TYPE_ENTRIES = 16,
    parameter int LENGTH_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tlvp_in_if.sink     i_in,
    tlvp_out_if.source  o_out,
    tlvp_cfg_if.sink    i_cfg
);
    import tlvp_pkg::*;

    localparam int IDX_W = $clog2(TYPE_ENTRIES);
    localparam int LB    = LENGTH_BITS;

    // configuration
    logic [MAXTYPE_W-1:0] r_max_type;
    logic                 r_policy_on;

    // walker state
    t_phase               r_phase, n_phase;
    logic [23:0]          r_hdr_shift, n_hdr_shift;
    logic [1:0]           r_hdr_cnt, n_hdr_cnt;
    logic [LB-1:0]        r_rem, n_rem;
    logic [LB-1:0]        r_rem_after, n_rem_after;
    logic [LB-1:0]        r_pos, n_pos;
    logic [LB-1:0]        r_offset, n_offset;
    logic [LEN_W-1:0]     r_payload_left, n_payload_left;
    logic [1:0]           r_pad_left, n_pad_left;
    logic [TYPE_W-1:0]    r_type, n_type;
    logic [LEN_W-1:0]     r_plen, n_plen;
    logic                 r_ignored, n_ignored;
    logic                 r_check_str, n_check_str;
    logic [TYPE_ENTRIES-1:0] r_seen, n_seen;
    t_policy              r_policy [TYPE_ENTRIES];

    logic                 accept;
    logic                 space_ok;
    logic [BYTE_W-1:0]    b;

    // header decode, valid when the fourth header byte arrives
    logic [LEN_W-1:0]     h_len;
    logic [TYPE_W-1:0]    h_type;
    logic                 h_ign;
    logic [IDX_W-1:0]     h_idx;
    t_policy              h_pol;
    logic [LEN_W-1:0]     h_plen;
    logic [LEN_W-1:0]     h_min;
    logic                 h_bad;
    logic [LEN_W-1:0]     h_avail;
    logic [1:0]           h_pad_full;
    logic [1:0]           h_pad_left;
    logic [LB-1:0]        h_rem_after;
    logic                 h_check;
    t_status              h_stat;
    logic                 h_chk_str;

    // attribute completion sources
    logic [TYPE_W-1:0]    c_type;
    logic                 c_ign;
    logic [IDX_W-1:0]     c_idx;
    logic [LEN_W-1:0]     c_plen;
    logic [1:0]           c_pad;
    logic [LB-1:0]        c_rem_after;
    logic                 c_chk_str;

    // result build
    logic                 do_complete;
    logic                 rep_v;
    logic                 rep_dup;
    logic                 sum_v;
    t_status              sum_st;
    logic [LB-1:0]        sum_left;
    logic                 push0, push1;
    t_result              res0, res1;
    t_result              q_data;
    logic                 q_valid;

    assign accept       = i_in.valid && i_in.ready;
    assign i_in.ready   = space_ok;
    assign i_cfg.ready  = 1'b1;
    assign b            = i_in.data.data_byte;

    // header fields: length is bytes 0..1, type is byte 2 and this byte
    always_comb begin
        h_len      = r_hdr_shift[15:0];
        h_type     = TYPE_W'({b, r_hdr_shift[23:16]});
        h_ign      = (h_type > TYPE_W'(r_max_type)) || (32'(h_type) >= TYPE_ENTRIES);
        h_idx      = IDX_W'(h_type);
        h_pol      = r_policy[h_idx];
        h_plen     = h_len - HDR_BYTES;
        h_min      = (h_pol.min_len != '0) ? h_pol.min_len
                                           : LEN_W'(f_default_min(h_pol.kind[3:0]));
        h_bad      = (h_len < HDR_BYTES) || (h_len > LEN_W'(r_rem));
        h_avail    = LEN_W'(r_rem) - h_len;
        h_pad_full = 2'd0 - h_len[1:0];
        h_pad_left = (LEN_W'(h_pad_full) < h_avail) ? h_pad_full : h_avail[1:0];
        h_rem_after = LB'(h_avail - LEN_W'(h_pad_left));
        h_check    = r_policy_on && !h_ign;
        if (!h_check) begin
            h_stat = ST_OK;
        end else if (h_pol.kind > KIND_LIMIT) begin
            h_stat = ST_BAD_KIND;
        end else if (h_plen < h_min) begin
            h_stat = ST_TOO_SHORT;
        end else if ((h_pol.max_len != '0) && (h_plen > h_pol.max_len)) begin
            h_stat = ST_TOO_LONG;
        end else begin
            h_stat = ST_OK;
        end
        h_chk_str  = h_check && (h_pol.kind == KIND_STRING);
    end

    // completion source: straight from the header when the payload is empty
    always_comb begin
        if (r_phase == PH_HEADER) begin
            c_type      = h_type;
            c_ign       = h_ign;
            c_plen      = h_plen;
            c_pad       = h_pad_left;
            c_rem_after = h_rem_after;
            c_chk_str   = h_chk_str;
        end else begin
            c_type      = r_type;
            c_ign       = r_ignored;
            c_plen      = r_plen;
            c_pad       = r_pad_left;
            c_rem_after = r_rem_after;
            c_chk_str   = r_check_str;
        end
        c_idx = IDX_W'(c_type);
    end

    // walker next state and results
    always_comb begin
        n_phase        = r_phase;
        n_hdr_shift    = r_hdr_shift;
        n_hdr_cnt      = r_hdr_cnt;
        n_rem          = r_rem;
        n_rem_after    = r_rem_after;
        n_pos          = r_pos;
        n_offset       = r_offset;
        n_payload_left = r_payload_left;
        n_pad_left     = r_pad_left;
        n_type         = r_type;
        n_plen         = r_plen;
        n_ignored      = r_ignored;
        n_check_str    = r_check_str;
        n_seen         = r_seen;
        do_complete    = 1'b0;
        rep_v          = 1'b0;
        rep_dup        = 1'b0;
        sum_v          = 1'b0;
        sum_st         = ST_OK;
        sum_left       = r_rem;

        if (accept) begin
            case (i_in.data.command)
                CMD_BEGIN: begin
                    n_rem       = LB'(i_in.data.stream_length);
                    n_pos       = '0;
                    n_seen      = '0;
                    n_hdr_cnt   = '0;
                    n_hdr_shift = '0;
                    if (n_rem < LB'(4)) begin
                        sum_v    = 1'b1;
                        sum_left = n_rem;
                        n_phase  = PH_IDLE;
                    end else begin
                        n_phase  = PH_HEADER;
                    end
                end
                CMD_BYTE: begin
                    case (r_phase)
                        PH_HEADER: begin
                            n_pos     = r_pos + LB'(1);
                            n_hdr_cnt = r_hdr_cnt + 2'd1;
                            case (r_hdr_cnt)
                                2'd0: begin
                                    n_offset          = r_pos;
                                    n_hdr_shift[7:0]  = b;
                                end
                                2'd1: n_hdr_shift[15:8]  = b;
                                2'd2: n_hdr_shift[23:16] = b;
                                default: begin
                                    // header complete
                                    if (h_bad) begin
                                        sum_v   = 1'b1;
                                        n_phase = PH_IDLE;
                                    end else if (h_stat != ST_OK) begin
                                        sum_v   = 1'b1;
                                        sum_st  = h_stat;
                                        n_phase = PH_IDLE;
                                    end else begin
                                        n_type         = h_type;
                                        n_plen         = h_plen;
                                        n_ignored      = h_ign;
                                        n_check_str    = h_chk_str;
                                        n_pad_left     = h_pad_left;
                                        n_rem_after    = h_rem_after;
                                        n_payload_left = h_plen;
                                        if (h_plen == '0) begin
                                            do_complete = 1'b1;
                                        end else begin
                                            n_phase = PH_PAYLOAD;
                                        end
                                    end
                                end
                            endcase
                        end
                        PH_PAYLOAD: begin
                            n_pos = r_pos + LB'(1);
                            if (r_payload_left != '0) begin
                                n_payload_left = r_payload_left - LEN_W'(1);
                            end
                            if (n_payload_left == '0) begin
                                do_complete = 1'b1;
                            end
                        end
                        PH_PAD: begin
                            n_pos = r_pos + LB'(1);
                            if (r_pad_left != '0) begin
                                n_pad_left = r_pad_left - 2'd1;
                            end
                            if (n_pad_left == '0) begin
                                n_rem = r_rem_after;
                                if (r_rem_after < LB'(4)) begin
                                    sum_v    = 1'b1;
                                    sum_left = r_rem_after;
                                    n_phase  = PH_IDLE;
                                end else begin
                                    n_phase  = PH_HEADER;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase

            // attribute complete: string check, report, maybe end of walk
            if (do_complete) begin
                if (c_chk_str && (b != '0)) begin
                    sum_v   = 1'b1;
                    sum_st  = ST_UNTERM;
                    n_phase = PH_IDLE;
                end else begin
                    rep_v = 1'b1;
                    if (!c_ign) begin
                        rep_dup       = r_seen[c_idx];
                        n_seen[c_idx] = 1'b1;
                    end
                    if (c_pad == '0) begin
                        n_rem = c_rem_after;
                        if (c_rem_after < LB'(4)) begin
                            sum_v    = 1'b1;
                            sum_left = c_rem_after;
                            n_phase  = PH_IDLE;
                        end else begin
                            n_phase  = PH_HEADER;
                        end
                    end else begin
                        n_phase = PH_PAD;
                    end
                end
            end
        end
    end

    // result ordering: report first, summary last
    always_comb begin
        push0 = 1'b0;
        push1 = 1'b0;
        res0  = f_summary(sum_st, LEN_W'(sum_left), 1'b1);
        res1  = f_summary(sum_st, LEN_W'(sum_left), 1'b1);
        if (rep_v) begin
            push0 = 1'b1;
            push1 = sum_v;
            res0  = f_report(c_type, LEN_W'(r_offset), c_plen, rep_dup, c_ign, !sum_v);
        end else if (sum_v) begin
            push0 = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_hdr_cnt <= '0;
            r_seen    <= '0;
        end else begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_seen    <= n_seen;
        end
    end

    // walk data registers
    always_ff @(posedge i_clk) begin
        r_hdr_shift    <= n_hdr_shift;
        r_rem          <= n_rem;
        r_rem_after    <= n_rem_after;
        r_pos          <= n_pos;
        r_offset       <= n_offset;
        r_payload_left <= n_payload_left;
        r_pad_left     <= n_pad_left;
        r_type         <= n_type;
        r_plen         <= n_plen;
        r_ignored      <= n_ignored;
        r_check_str    <= n_check_str;
    end

    // policy table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TYPE_ENTRIES; i++) begin
                r_policy[i] <= '0;
            end
        end else if (accept && (i_in.data.command == CMD_POLICY)
                     && (32'(i_in.data.entry_index) < TYPE_ENTRIES)) begin
            r_policy[IDX_W'(i_in.data.entry_index)] <= '{
                kind:    i_in.data.entry_kind,
                min_len: i_in.data.entry_min_len,
                max_len: i_in.data.entry_max_len
            };
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_type  <= 4'd15;
            r_policy_on <= 1'b0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_MAX_TYPE:  r_max_type  <= MAXTYPE_W'(i_cfg.wdata);
                CFG_POLICY_ON: r_policy_on <= i_cfg.wdata[0];
                default: ;
            endcase
        end
    end

    tlvp_result_fifo u_result_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push0    (push0),
        .i_push1    (push1),
        .i_data0    (res0),
        .i_data1    (res1),
        .o_space_ok (space_ok),
        .o_valid    (q_valid),
        .o_data     (q_data),
        .i_ready    (o_out.ready)
    );

    assign o_out.valid = q_valid;
    assign o_out.data  = q_data;

endmodule

[tb/tlv_attribute_policy_parser_top_tb.sv]
`timescale 1ns / 1ps

import tlvp_pkg::*;

// Tracks the attribute walk and the results it owes
class tlv_walk_scoreboard;
    // register copies
    logic [3:0]  max_type;
    logic        policy_on;

    // walker state
    t_phase      phase;
    logic [31:0] hdr_shift;
    logic [1:0]  hdr_count;
    int unsigned remain;
    logic [15:0] position;
    int unsigned pay_left;
    int unsigned pad_left;
    logic [15:0] seen;
    t_policy     policy [16];

    // attribute under parse
    logic [13:0] a_type;
    logic [15:0] a_offset;
    int unsigned a_plen;
    int unsigned a_aligned;
    logic [7:0]  a_last_byte;
    bit          a_ignored;
    bit          a_check_str;

    t_result     results_due [$];
    t_result     step_out [$];

    int errors;
    int n_reports;
    int n_dup;
    int n_ign;
    int n_summaries;
    int n_policy_err;

    function new();
        max_type    = 4'd15;
        policy_on   = 1'b0;
        phase       = PH_IDLE;
        hdr_shift   = '0;
        hdr_count   = '0;
        remain      = 0;
        position    = '0;
        pay_left    = 0;
        pad_left    = 0;
        seen        = '0;
        a_type      = '0;
        a_offset    = '0;
        a_plen      = 0;
        a_aligned   = 0;
        a_last_byte = '0;
        a_ignored   = 0;
        a_check_str = 0;
        foreach (policy[i]) policy[i] = '0;
        errors       = 0;
        n_reports    = 0;
        n_dup        = 0;
        n_ign        = 0;
        n_summaries  = 0;
        n_policy_err = 0;
    endfunction

    function int pending();
        return results_due.size();
    endfunction

    function void write_reg(logic [3:0] idx, logic [3:0] val);
        case (idx)
            CFG_MAX_TYPE:  max_type  = val;
            CFG_POLICY_ON: policy_on = val[0];
            default: ;
        endcase
    endfunction

    // default minimum payload of a kind
    function int unsigned kind_floor(logic [3:0] k);
        case (k)
            4'd1:    return 1;
            4'd2:    return 2;
            4'd3:    return 4;
            4'd4:    return 8;
            4'd5:    return 1;
            default: return 0;
        endcase
    endfunction

    function void emit_summary(t_status st);
        t_result r;
        r          = '0;
        r.kind     = RES_SUMMARY;
        r.status   = st;
        r.leftover = 16'(remain);
        step_out.push_back(r);
        phase = PH_IDLE;
    endfunction

    // consume the aligned size, end the walk when under a header is left
    function void end_attribute();
        remain = (remain >= a_aligned) ? remain - a_aligned : 0;
        if (remain < 4)
            emit_summary(ST_OK);
        else
            phase = PH_HEADER;
    endfunction

    function void payload_done();
        t_result r;
        bit      dup;
        dup = 0;
        if (a_check_str && a_last_byte != 8'd0) begin
            emit_summary(ST_UNTERM);
            return;
        end
        if (!a_ignored) begin
            dup = seen[a_type[3:0]];
            seen[a_type[3:0]] = 1'b1;
        end
        r                = '0;
        r.kind           = RES_REPORT;
        r.attr_type      = a_type;
        r.attr_offset    = a_offset;
        r.payload_length = 16'(a_plen);
        r.duplicate      = dup;
        r.ignored        = a_ignored;
        step_out.push_back(r);
        if (pad_left == 0)
            end_attribute();
        else
            phase = PH_PAD;
    endfunction

    // header complete: length sanity, then policy checks
    function void header_done();
        int unsigned hlen;
        logic [15:0] htype;
        int unsigned pad_full;
        int unsigned avail;
        int unsigned minl;
        t_policy     p;
        hlen  = hdr_shift[15:0];
        htype = hdr_shift[31:16];
        if (hlen < 4 || hlen > remain) begin
            emit_summary(ST_OK);
            return;
        end
        a_type      = htype[13:0];
        a_plen      = hlen - 4;
        a_last_byte = htype[15:8];
        a_ignored   = (a_type > max_type) || (a_type >= 16);
        a_check_str = 0;
        pad_full    = (hlen % 4 == 0) ? 0 : 4 - (hlen % 4);
        a_aligned   = hlen + pad_full;
        avail       = remain - hlen;
        pad_left    = (pad_full < avail) ? pad_full : avail;
        if (!a_ignored && policy_on) begin
            p = policy[a_type[3:0]];
            if (p.kind > KIND_LIMIT) begin
                emit_summary(ST_BAD_KIND);
                return;
            end
            minl = (p.min_len != 0) ? p.min_len : kind_floor(p.kind[3:0]);
            if (a_plen < minl) begin
                emit_summary(ST_TOO_SHORT);
                return;
            end
            if (p.max_len != 0 && a_plen > p.max_len) begin
                emit_summary(ST_TOO_LONG);
                return;
            end
            a_check_str = (p.kind == KIND_STRING);
        end
        pay_left = a_plen;
        if (pay_left == 0)
            payload_done();
        else
            phase = PH_PAYLOAD;
    endfunction

    function void consume_byte(logic [7:0] b);
        position = position + 16'd1;
        case (phase)
            PH_HEADER: begin
                if (hdr_count == 2'd0) begin
                    a_offset  = position - 16'd1;
                    hdr_shift = '0;
                end
                hdr_shift = hdr_shift | (32'(b) << (8 * hdr_count));
                hdr_count = hdr_count + 2'd1;
                if (hdr_count == 2'd0)
                    header_done();
            end
            PH_PAYLOAD: begin
                a_last_byte = b;
                if (pay_left > 0)
                    pay_left--;
                if (pay_left == 0)
                    payload_done();
            end
            default: begin
                if (pad_left > 0)
                    pad_left--;
                if (pad_left == 0)
                    end_attribute();
            end
        endcase
    endfunction

    // accepted request: update the walk and queue what it owes
    function void note_request(t_in_item req);
        step_out.delete();
        case (req.command)
            CMD_BEGIN: begin
                remain    = req.stream_length;
                position  = '0;
                seen      = '0;
                hdr_count = '0;
                hdr_shift = '0;
                if (remain < 4)
                    emit_summary(ST_OK);
                else
                    phase = PH_HEADER;
            end
            CMD_POLICY: begin
                policy[req.entry_index].kind    = req.entry_kind;
                policy[req.entry_index].min_len = req.entry_min_len;
                policy[req.entry_index].max_len = req.entry_max_len;
            end
            CMD_BYTE: begin
                if (phase != PH_IDLE)
                    consume_byte(req.data_byte);
            end
            default: ;
        endcase
        if (step_out.size() > 0)
            step_out[step_out.size() - 1].last = 1'b1;
        foreach (step_out[i]) results_due.push_back(step_out[i]);
    endfunction

    function void match(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_result(t_result got);
        t_result want;
        if (results_due.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            errors++;
            return;
        end
        want = results_due.pop_front();
        match("kind", 16'(want.kind), 16'(got.kind));
        match("attr_type", 16'(want.attr_type), 16'(got.attr_type));
        match("attr_offset", want.attr_offset, got.attr_offset);
        match("payload_length", want.payload_length, got.payload_length);
        match("duplicate", 16'(want.duplicate), 16'(got.duplicate));
        match("ignored", 16'(want.ignored), 16'(got.ignored));
        match("status", 16'(want.status), 16'(got.status));
        match("leftover", want.leftover, got.leftover);
        match("last", 16'(want.last), 16'(got.last));
        if (want.kind == RES_REPORT) begin
            n_reports++;
            n_dup += want.duplicate;
            n_ign += want.ignored;
        end else begin
            n_summaries++;
            if (want.status != ST_OK)
                n_policy_err++;
        end
    endfunction
endclass

module tlv_attribute_policy_parser_top_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_PHASES       = 6;
    localparam int PHASE_ITEMS    = 90;

    logic i_clk;
    logic i_rst_n;

    tlvp_in_if  in_bus ();
    tlvp_out_if out_bus ();
    tlvp_cfg_if cfg_bus ();

    tlv_walk_scoreboard sb = new();

    int  idle_cycles = 0;
    int  n_sent      = 0;
    int  n_cfg       = 0;
    int  n_drains    = 0;
    int  in_idle_pct = 10;
    int  stall_pct   = 10;

    tlv_attribute_policy_parser_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Receiver: random stall bursts
    initial begin
        int stall_left;
        stall_left    = 0;
        out_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                out_bus.ready <= 1'b0;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                stall_left    = $urandom_range(1, 8) - 1;
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    // Sample handshakes at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_bus.valid && out_bus.ready)
                sb.check_result(out_bus.data);
            if (in_bus.valid && in_bus.ready)
                sb.note_request(in_bus.data);
            if (cfg_bus.valid && cfg_bus.ready) begin
                sb.write_reg(cfg_bus.index, cfg_bus.wdata);
                n_cfg++;
            end
            if ((out_bus.valid && out_bus.ready) || (in_bus.valid && in_bus.ready) ||
                (cfg_bus.valid && cfg_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // Watchdog on a stuck handshake
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("%0t: no handshake for %0d cycles, %0d results still due",
                 $time, WATCHDOG_LIMIT, sb.pending());
        $display("== FAIL ==");
        $finish;
    end

    function automatic t_in_item rand_fill();
        t_in_item it;
        it.command       = CMD_NOP;
        it.stream_length = 16'($urandom);
        it.data_byte     = 8'($urandom);
        it.entry_index   = 4'($urandom);
        it.entry_kind    = 5'($urandom);
        it.entry_min_len = 16'($urandom);
        it.entry_max_len = 16'($urandom);
        return it;
    endfunction

    task automatic idle_in(int n);
        repeat (n) begin
            @(negedge i_clk);
            in_bus.valid <= 1'b0;
        end
    endtask

    task automatic send_item(t_in_item it);
        if ($urandom_range(0, 99) < in_idle_pct)
            idle_in($urandom_range(1, 8));
        @(negedge i_clk);
        in_bus.valid <= 1'b1;
        in_bus.data  <= it;
        do @(posedge i_clk); while (!in_bus.ready);
        n_sent++;
    endtask

    task automatic send_begin(int unsigned len);
        t_in_item it;
        it               = rand_fill();
        it.command       = CMD_BEGIN;
        it.stream_length = 16'(len);
        send_item(it);
    endtask

    task automatic send_byte(logic [7:0] b);
        t_in_item it;
        it           = rand_fill();
        it.command   = CMD_BYTE;
        it.data_byte = b;
        send_item(it);
    endtask

    task automatic send_nop();
        t_in_item it;
        it         = rand_fill();
        it.command = CMD_NOP;
        send_item(it);
    endtask

    task automatic send_policy(logic [3:0] idx, logic [4:0] kind,
                               logic [15:0] min_len, logic [15:0] max_len);
        t_in_item it;
        it               = rand_fill();
        it.command       = CMD_POLICY;
        it.entry_index   = idx;
        it.entry_kind    = kind;
        it.entry_min_len = min_len;
        it.entry_max_len = max_len;
        send_item(it);
    endtask

    // Policy entry biased toward usable kinds and small limits
    task automatic send_random_policy();
        logic [4:0]  kind;
        logic [15:0] min_len;
        logic [15:0] max_len;
        int          r;
        r = $urandom_range(0, 19);
        if (r < 12)
            kind = 5'($urandom_range(0, 5));
        else if (r < 17)
            kind = 5'($urandom_range(6, 15));
        else
            kind = 5'($urandom_range(16, 31));
        r = $urandom_range(0, 9);
        min_len = (r < 6) ? 16'd0 : (r < 9) ? 16'($urandom_range(1, 12)) : 16'($urandom);
        r = $urandom_range(0, 9);
        max_len = (r < 5) ? 16'd0 : (r < 9) ? 16'($urandom_range(1, 16)) : 16'($urandom);
        send_policy(4'($urandom_range(0, 15)), kind, min_len, max_len);
    endtask

    // Begin a walk and feed the first stop bytes of the stream, with stray policy or nop requests when noisy
    task automatic play_stream(int unsigned len, logic [7:0] seq[$], int unsigned stop,
                               bit noisy);
        send_begin(len);
        for (int j = 0; j < stop; j++) begin
            if (noisy && $urandom_range(0, 24) == 0) begin
                if ($urandom_range(0, 1))
                    send_random_policy();
                else
                    send_nop();
            end
            send_byte(seq[j]);
        end
    endtask

    // Mostly well-formed attribute stream with random content
    task automatic run_walk();
        logic [7:0]  seq[$];
        logic [15:0] hdr_len;
        logic [15:0] hdr_type;
        logic [7:0]  b;
        int unsigned n_attr;
        int unsigned plen;
        int unsigned stop;
        n_attr = $urandom_range(1, 4);
        for (int k = 0; k < n_attr; k++) begin
            plen    = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 9);
            hdr_len = 16'(plen + 4);
            case ($urandom_range(0, 9))
                0:       hdr_type = 16'($urandom);
                1:       hdr_type = {2'($urandom), 14'($urandom_range(16, 16383))};
                2, 3:    hdr_type = {2'($urandom), 14'($urandom_range(0, 3))};
                default: hdr_type = {2'($urandom), 14'($urandom_range(0, 15))};
            endcase
            // occasional broken length field
            if ($urandom_range(0, 19) == 0)
                hdr_len = $urandom_range(0, 1) ? 16'($urandom_range(0, 3)) : 16'($urandom);
            seq.push_back(hdr_len[7:0]);
            seq.push_back(hdr_len[15:8]);
            seq.push_back(hdr_type[7:0]);
            seq.push_back(hdr_type[15:8]);
            for (int j = 0; j < plen; j++) begin
                b = 8'($urandom);
                if (j == plen - 1 && $urandom_range(0, 1))
                    b = 8'd0;
                seq.push_back(b);
            end
            while (seq.size() % 4 != 0)
                seq.push_back(8'($urandom));
        end
        // trailing bytes or a cut tail
        case ($urandom_range(0, 9))
            0, 1: repeat ($urandom_range(1, 3)) seq.push_back(8'($urandom));
            2:    repeat ($urandom_range(4, 7)) seq.push_back(8'($urandom));
            3:    repeat ($urandom_range(1, 3)) void'(seq.pop_back());
            default: ;
        endcase
        stop = seq.size();
        if ($urandom_range(0, 14) == 0)
            stop = $urandom_range(0, seq.size() - 1);
        play_stream(seq.size(), seq, stop, 1'b1);
        // bytes after the walk has ended are ignored
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
    endtask

    // Hold the sender until every owed result has come out
    task automatic drain();
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        n_drains++;
    endtask

    task automatic write_reg(logic [3:0] idx, logic [3:0] val);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.wdata <= val;
        do @(posedge i_clk); while (!cfg_bus.ready);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    initial begin
        logic [7:0] seq[$];
        int         max_sel [N_PHASES];
        bit         pol_sel [N_PHASES];
        int         idle_sel [N_PHASES];
        int         start;
        bit         paused;

        max_sel  = '{15, 0, 7, 15, 3, 15};
        pol_sel  = '{1, 1, 0, 1, 1, 1};
        idle_sel = '{10, 25, 0, 15, 30, 0};

        i_rst_n       = 1'b0;
        in_bus.valid  = 1'b0;
        in_bus.data   = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = '0;
        cfg_bus.wdata = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every command, field extremes, each walk ending that needs no policy check
        send_nop();
        send_byte(8'hFF);                               // byte with no walk
        send_policy(4'd15, 5'd31, 16'hFFFF, 16'hFFFF);
        send_policy(4'd0, 5'd0, 16'h0000, 16'h0000);
        send_begin(0);                                  // short stream
        send_begin(3);
        seq = '{8'h04, 8'h00, 8'h01, 8'h00};            // empty payload, report and end together
        play_stream(4, seq, seq.size(), 1'b0);
        seq = '{8'h05, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h7E}; // flagged type, pad past the end
        play_stream(6, seq, seq.size(), 1'b0);
        seq = '{8'h03, 8'h00, 8'h00, 8'h00};            // length under a header
        play_stream(16'hFFFF, seq, seq.size(), 1'b0);
        seq = '{8'hFF, 8'hFF, 8'h00, 8'h00};            // length past the stream
        play_stream(9, seq, seq.size(), 1'b0);

        // Random phases, each under its own register setting
        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            write_reg(CFG_MAX_TYPE, 4'(max_sel[ph]));
            write_reg(CFG_POLICY_ON, {3'($urandom), pol_sel[ph]});
            in_idle_pct = idle_sel[ph];
            stall_pct   = idle_sel[ph];
            repeat ($urandom_range(3, 6)) send_random_policy();
            start  = n_sent;
            paused = 0;
            while (n_sent - start < PHASE_ITEMS) begin
                if (!paused && n_sent - start >= PHASE_ITEMS / 2) begin
                    drain();
                    paused = 1;
                end
                case ($urandom_range(0, 9))
                    0: begin
                        // arbitrary length and bytes, then a restart
                        send_begin(16'($urandom));
                        repeat ($urandom_range(2, 10)) send_byte(8'($urandom));
                    end
                    1: repeat ($urandom_range(1, 2)) send_random_policy();
                    default: run_walk();
                endcase
            end
        end

        idle_in(1);
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Run: %0d requests, %0d reports (%0d duplicate, %0d ignored), %0d summaries",
                 n_sent, sb.n_reports, sb.n_dup, sb.n_ign, sb.n_summaries);
        $display("     %0d walks ended on a policy error, %0d register writes, %0d drains",
                 sb.n_policy_err, n_cfg, n_drains);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/tlvp_pkg.sv
rtl/core/tlvp_in_if.sv
rtl/core/tlvp_out_if.sv
rtl/core/tlvp_cfg_if.sv
rtl/core/tlvp_result_fifo.sv
rtl/core/tlv_attribute_policy_parser_top.sv
tb/tlv_attribute_policy_parser_top_tb.sv
